/* src/chlcd_pkg.sv */
`timescale 1ns / 1ps

package chlcd_pkg;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_BYTE   = 2'd1,
        MODE_NIBBLE = 2'd2,
        MODE_START  = 2'd3
    } t_mode;

    localparam logic CFG_CHIP_VARIANT = 1'b0;
    localparam logic CFG_PHASE_TICKS  = 1'b1;

    localparam logic [3:0] START_NIBBLE = 4'h2;
    localparam logic [7:0] FSET_STD     = 8'h2C;
    localparam logic [7:0] FSET_ALT     = 8'h29;
    localparam logic [7:0] START_TAIL   = 8'd39;
    localparam logic [7:0] PHASE_RESET  = 8'd20;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

endpackage

/* src/char_lcd_nibble_write_sequencer_top.sv */
`timescale 1ns / 1ps
// Each result is registered as its item transfers (skid if output is held).
// Throughput: one item per cycle while the skid entry is empty; the two-entry
// output stage (register plus skid) keeps input ready while one result waits.
// Reset: synchronous, active low; clears sequencer state, configuration to its
// defaults (standard chip, 20 ticks per phase) and both output entries.

module char_lcd_nibble_write_sequencer_top #(
    parameter int DELAY_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // reg_select[0], payload[8:1], extra_delay[24:9], zero[31:25]
    input  logic [chlcd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // mode[1:0]
    input  logic [chlcd_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // rs_pin[0], enable_pin[1], bus_nibble[5:2], busy_res[6], rejected[7]
    output logic [chlcd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_addr,
    input  logic [7:0]                          i_cfg_data
);

    localparam int WCW = DELAY_BITS + 1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SETUP  = 2'd1,
        PH_STROBE = 2'd2,
        PH_HOLD   = 2'd3
    } t_phase;

    logic                  r_chip_variant;
    logic [7:0]            r_phase_ticks;
    t_phase                r_phase, n_phase;
    logic [11:0]           r_queue, n_queue;
    logic [1:0]            r_left, n_left;
    logic                  r_rs, n_rs;
    logic [DELAY_BITS-1:0] r_tail, n_tail;
    logic [WCW-1:0]        r_wait, n_wait;
    logic                  r_en, n_en;
    logic [3:0]            r_data, n_data;
    logic                  n_rej;

    logic                        r_out_valid, r_skid_valid;
    logic [chlcd_pkg::OUT_DATA_W-1:0] r_out_data, r_skid_data, n_result;

    chlcd_pkg::t_mode      in_mode;
    logic                  in_rs;
    logic [7:0]            in_pay;
    logic [31:0]           in_dly_ext;
    logic [DELAY_BITS-1:0] in_dly;
    logic [WCW-1:0]        plen, wait_dec, tail_add;
    logic                  s_fire, m_fire;

    assign in_mode    = chlcd_pkg::t_mode'(s_axis_tuser[1:0]);
    assign in_rs      = s_axis_tdata[0];
    assign in_pay     = s_axis_tdata[8:1];
    assign in_dly_ext = {16'd0, s_axis_tdata[24:9]};
    assign in_dly     = in_dly_ext[DELAY_BITS-1:0];

    assign s_axis_tready = !r_skid_valid;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_fire        = r_out_valid && m_axis_tready;

    assign plen     = (r_phase_ticks == 8'd0) ? WCW'(1) : WCW'(r_phase_ticks);
    assign wait_dec = (r_wait != '0) ? r_wait - WCW'(1) : r_wait;
    assign tail_add = (r_left <= 2'd1) ? WCW'(r_tail) : '0;

    always_comb begin
        n_phase = r_phase;
        n_queue = r_queue;
        n_left  = r_left;
        n_rs    = r_rs;
        n_tail  = r_tail;
        n_wait  = r_wait;
        n_en    = r_en;
        n_data  = r_data;
        n_rej   = 1'b0;
        if (in_mode == chlcd_pkg::MODE_TICK) begin
            if (r_phase != PH_IDLE) begin
                n_wait = wait_dec;
                if (wait_dec == '0) begin
                    unique case (r_phase)
                        PH_SETUP: begin
                            n_phase = PH_STROBE;
                            n_en    = 1'b1;
                            n_data  = r_queue[11:8];
                            n_wait  = plen;
                        end
                        PH_STROBE: begin
                            n_phase = PH_HOLD;
                            n_en    = 1'b0;
                            n_wait  = plen + tail_add;
                        end
                        PH_HOLD: begin
                            n_queue = {r_queue[7:0], 4'h0};
                            n_left  = (r_left != 2'd0) ? r_left - 2'd1 : 2'd0;
                            if (n_left != 2'd0) begin
                                n_phase = PH_SETUP;
                                n_wait  = plen;
                            end else begin
                                n_phase = PH_IDLE;
                                n_wait  = '0;
                            end
                        end
                        default: n_wait = '0;
                    endcase
                end
            end
        end else if (r_phase != PH_IDLE) begin
            n_rej = 1'b1;
        end else begin
            unique case (in_mode)
                chlcd_pkg::MODE_BYTE: begin
                    n_queue = {in_pay, 4'h0};
                    n_left  = 2'd2;
                    n_rs    = in_rs;
                    n_tail  = in_dly;
                end
                chlcd_pkg::MODE_NIBBLE: begin
                    n_queue = {in_pay[3:0], 8'h00};
                    n_left  = 2'd1;
                    n_rs    = in_rs;
                    n_tail  = in_dly;
                end
                default: begin
                    n_queue = {chlcd_pkg::START_NIBBLE,
                               r_chip_variant ? chlcd_pkg::FSET_ALT : chlcd_pkg::FSET_STD};
                    n_left  = 2'd3;
                    n_rs    = 1'b0;
                    n_tail  = DELAY_BITS'(chlcd_pkg::START_TAIL);
                end
            endcase
            n_phase = PH_SETUP;
            n_en    = 1'b0;
            n_wait  = plen;
        end
        n_result = {n_rej, (n_phase != PH_IDLE), n_data, n_en, n_rs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_variant <= 1'b0;
            r_phase_ticks  <= chlcd_pkg::PHASE_RESET;
            r_phase        <= PH_IDLE;
            r_queue        <= '0;
            r_left         <= '0;
            r_rs           <= 1'b0;
            r_tail         <= '0;
            r_wait         <= '0;
            r_en           <= 1'b0;
            r_data         <= '0;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    chlcd_pkg::CFG_CHIP_VARIANT: r_chip_variant <= i_cfg_data[0];
                    chlcd_pkg::CFG_PHASE_TICKS:  r_phase_ticks  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_fire) begin
                r_phase <= n_phase;
                r_queue <= n_queue;
                r_left  <= n_left;
                r_rs    <= n_rs;
                r_tail  <= n_tail;
                r_wait  <= n_wait;
                r_en    <= n_en;
                r_data  <= n_data;
                if (!r_out_valid || m_axis_tready) begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= n_result;
                end else begin
                    r_skid_valid <= 1'b1;
                    r_skid_data  <= n_result;
                end
            end else if (m_fire) begin
                if (r_skid_valid) begin
                    r_out_data   <= r_skid_data;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_enable_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_en == (r_phase == PH_STROBE))
        else $error("enable level out of step with phase");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_wait == '0 && r_left == 2'd0))
        else $error("idle with pending count or nibbles");

    a_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && r_phase == PH_IDLE && s_axis_tuser != chlcd_pkg::MODE_TICK)
        |=> (r_phase == PH_SETUP && r_wait != '0))
        else $error("accepted command did not enter setup");

endmodule

/* tb/tb_char_lcd_nibble_write_sequencer_top.sv */
`timescale 1ns / 1ps

module tb_char_lcd_nibble_write_sequencer_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 780;
    localparam int DIR_ROWS = 25;
    localparam int TAIL_TICKS = 530;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SETUP  = 2'd1,
        PH_STROBE = 2'd2,
        PH_HOLD   = 2'd3
    } t_lcd_phase;

    // rs_pin[0], enable_pin[1], bus_nibble[5:2], busy_res[6], rejected[7]
    typedef struct packed {
        logic       rejected;
        logic       busy;
        logic [3:0] nibble;
        logic       enable;
        logic       rs;
    } t_pins;

    typedef struct packed {
        chlcd_pkg::t_mode mode;
        logic             rs;
        logic [7:0]       payload;
        logic [15:0]      extra;
        logic             fixed;
        t_pins            pins;
    } t_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [chlcd_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [chlcd_pkg::IN_USER_W-1:0]   s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [chlcd_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic                              i_cfg_we = 1'b0;
    logic                              i_cfg_addr = 1'b0;
    logic [7:0]                        i_cfg_data = '0;

    char_lcd_nibble_write_sequencer_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // sequencer copy
    logic        cfg_variant = 1'b0;
    logic [7:0]  cfg_phase = chlcd_pkg::PHASE_RESET;
    t_lcd_phase  lcd_phase = PH_IDLE;
    logic [11:0] lcd_queue = '0;
    logic [1:0]  lcd_left = '0;
    logic        lcd_rs = 1'b0;
    logic [15:0] lcd_tail = '0;
    logic [16:0] lcd_wait = '0;
    logic        lcd_en = 1'b0;
    logic [3:0]  lcd_data = '0;

    t_pins pin_levels_q[$];
    int    items_sent = 0;
    int    mismatch_count = 0;
    int    cycle_count = 0;
    bit    steady_flow = 1'b0;

    function automatic logic [16:0] phase_len();
        return (cfg_phase == 8'd0) ? 17'd1 : {9'd0, cfg_phase};
    endfunction

    function automatic void lcd_advance();
        if (lcd_wait != 17'd0) lcd_wait = lcd_wait - 17'd1;
        if (lcd_wait != 17'd0) return;
        case (lcd_phase)
            PH_SETUP: begin
                lcd_phase = PH_STROBE;
                lcd_en    = 1'b1;
                lcd_data  = lcd_queue[11:8];
                lcd_wait  = phase_len();
            end
            PH_STROBE: begin
                lcd_phase = PH_HOLD;
                lcd_en    = 1'b0;
                lcd_wait  = phase_len() + ((lcd_left <= 2'd1) ? {1'b0, lcd_tail} : 17'd0);
            end
            PH_HOLD: begin
                lcd_queue = lcd_queue << 4;
                lcd_left  = (lcd_left > 2'd0) ? lcd_left - 2'd1 : 2'd0;
                if (lcd_left != 2'd0) begin
                    lcd_phase = PH_SETUP;
                    lcd_wait  = phase_len();
                end else begin
                    lcd_phase = PH_IDLE;
                    lcd_wait  = '0;
                end
            end
            default: lcd_wait = '0;
        endcase
    endfunction

    function automatic t_pins lcd_step(chlcd_pkg::t_mode mode, logic rs,
                                       logic [7:0] payload, logic [15:0] extra);
        t_pins pins;
        logic  rej;
        rej = 1'b0;
        if (mode == chlcd_pkg::MODE_TICK) begin
            if (lcd_phase != PH_IDLE) lcd_advance();
        end else if (lcd_phase != PH_IDLE) begin
            rej = 1'b1;
        end else begin
            case (mode)
                chlcd_pkg::MODE_BYTE: begin
                    lcd_queue = {payload, 4'h0};
                    lcd_left  = 2'd2;
                    lcd_rs    = rs;
                    lcd_tail  = extra;
                end
                chlcd_pkg::MODE_NIBBLE: begin
                    lcd_queue = {payload[3:0], 8'h00};
                    lcd_left  = 2'd1;
                    lcd_rs    = rs;
                    lcd_tail  = extra;
                end
                default: begin
                    lcd_queue = {chlcd_pkg::START_NIBBLE,
                                 cfg_variant ? chlcd_pkg::FSET_ALT : chlcd_pkg::FSET_STD};
                    lcd_left  = 2'd3;
                    lcd_rs    = 1'b0;
                    lcd_tail  = {8'd0, chlcd_pkg::START_TAIL};
                end
            endcase
            lcd_phase = PH_SETUP;
            lcd_en    = 1'b0;
            lcd_wait  = phase_len();
        end
        pins.rs       = lcd_rs;
        pins.enable   = lcd_en;
        pins.nibble   = lcd_data;
        pins.busy     = (lcd_phase != PH_IDLE);
        pins.rejected = rej;
        return pins;
    endfunction

    task automatic send_item(input chlcd_pkg::t_mode mode, input logic rs,
                             input logic [7:0] payload, input logic [15:0] extra,
                             input logic fixed, input t_pins pins);
        t_pins predicted;
        while (!steady_flow && $urandom_range(0, 99) < 31) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, extra, payload, rs};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = lcd_step(mode, rs, payload, extra);
        pin_levels_q.push_back(fixed ? pins : predicted);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(chlcd_pkg::MODE_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  16'($urandom), 1'b0, '0);
    endtask

    task automatic send_command();
        logic [15:0] extra;
        extra = ($urandom_range(0, 31) == 0) ? 16'($urandom_range(0, 255))
                                             : 16'($urandom_range(0, 7));
        send_item(chlcd_pkg::t_mode'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), extra, 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pin_levels_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_lcd_reg(input logic addr, input logic [7:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == chlcd_pkg::CFG_CHIP_VARIANT) cfg_variant = value[0];
        else cfg_phase = value;
    endtask

    task automatic pick_setting();
        logic [7:0] ticks;
        case ($urandom_range(0, 9))
            0:       ticks = 8'd0;
            7, 8:    ticks = 8'($urandom_range(4, 8));
            9:       ticks = 8'd20;
            default: ticks = 8'($urandom_range(1, 3));
        endcase
        if ($urandom_range(0, 1) == 0) begin
            write_lcd_reg(chlcd_pkg::CFG_CHIP_VARIANT, 8'($urandom_range(0, 1)));
        end else begin
            write_lcd_reg(chlcd_pkg::CFG_PHASE_TICKS, ticks);
        end
    endtask

    t_row dir_table [DIR_ROWS] = '{
        '{chlcd_pkg::MODE_TICK,   1'b1, 8'hFF, 16'hFFFF, 1'b1, '{1'b0, 1'b0, 4'h0, 1'b0, 1'b0}},
        '{chlcd_pkg::MODE_BYTE,   1'b1, 8'hA5, 16'h0000, 1'b1, '{1'b0, 1'b1, 4'h0, 1'b0, 1'b1}},
        '{chlcd_pkg::MODE_NIBBLE, 1'b0, 8'h5A, 16'h1234, 1'b1, '{1'b1, 1'b1, 4'h0, 1'b0, 1'b1}},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_NIBBLE, 1'b0, 8'hFF, 16'h0003, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_START,  1'b1, 8'hFF, 16'hFFFF, 1'b0, '0},
        '{chlcd_pkg::MODE_BYTE,   1'b1, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0},
        '{chlcd_pkg::MODE_TICK,   1'b0, 8'h00, 16'h0000, 1'b0, '0}
    };

    always @(posedge i_clk) begin
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 31);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("char_lcd_nibble_write_sequencer_top test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_pins got;
        t_pins want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_pins'(m_axis_tdata);
            if (pin_levels_q.size() == 0) begin
                $error("unexpected transfer: data %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pin_levels_q.pop_front();
                if (got.rs != want.rs) begin
                    $error("rs_pin: expected %0d, actual %0d", want.rs, got.rs);
                    mismatch_count++;
                end
                if (got.enable != want.enable) begin
                    $error("enable_pin: expected %0d, actual %0d", want.enable, got.enable);
                    mismatch_count++;
                end
                if (got.nibble != want.nibble) begin
                    $error("bus_nibble: expected %h, actual %h", want.nibble, got.nibble);
                    mismatch_count++;
                end
                if (got.busy != want.busy) begin
                    $error("busy_res: expected %0d, actual %0d", want.busy, got.busy);
                    mismatch_count++;
                end
                if (got.rejected != want.rejected) begin
                    $error("rejected: expected %0d, actual %0d", want.rejected, got.rejected);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_lcd_reg(chlcd_pkg::CFG_PHASE_TICKS, 8'd1);
        foreach (dir_table[i]) begin
            send_item(dir_table[i].mode, dir_table[i].rs, dir_table[i].payload,
                      dir_table[i].extra, dir_table[i].fixed, dir_table[i].pins);
        end

        write_lcd_reg(chlcd_pkg::CFG_CHIP_VARIANT, 8'd1);
        while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
            steady_flow = (items_sent >= 500) && (items_sent < 800);
            if ($urandom_range(0, 39) == 0) pick_setting();
            if (lcd_phase == PH_IDLE) begin
                if ($urandom_range(0, 99) < 80) send_command();
                else send_tick();
            end else if ($urandom_range(0, 99) < 6) begin
                send_command();
            end else begin
                send_tick();
            end
        end
        steady_flow = 1'b0;

        // longest phase and longest tail
        while (lcd_phase != PH_IDLE) send_tick();
        write_lcd_reg(chlcd_pkg::CFG_PHASE_TICKS, 8'd255);
        write_lcd_reg(chlcd_pkg::CFG_CHIP_VARIANT, 8'd0);
        send_item(chlcd_pkg::MODE_NIBBLE, 1'b1, 8'hFF, 16'hFFFF, 1'b0, '0);
        repeat (TAIL_TICKS) send_tick();
        send_item(chlcd_pkg::MODE_START, 1'b0, 8'h00, 16'h0000, 1'b0, '0);
        send_item(chlcd_pkg::MODE_BYTE, 1'b1, 8'hFF, 16'hFFFF, 1'b0, '0);
        send_tick();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("char_lcd_nibble_write_sequencer_top test passed");
        end else begin
            $display("char_lcd_nibble_write_sequencer_top test failed");
        end
        $finish;
    end

endmodule
